[hdl/qoi_pkg.sv]
// ============================================================================
// qoi_pkg
// Shared types, constants and helper functions of the QOI pixel stream decoder.
// ============================================================================
package qoi_pkg;

  // Pixel counts saturate at 2**COUNT_BITS.
  localparam int COUNT_BITS = 24;
  localparam int CNT_W      = COUNT_BITS + 1;
  localparam int PCOUNT_W   = 25;
  localparam int CMP_W      = (CNT_W > PCOUNT_W) ? CNT_W : PCOUNT_W;

  // Pixel index table.
  localparam int TABLE_DEPTH = 64;
  localparam int TIDX_W      = $clog2(TABLE_DEPTH);
  localparam int PIXEL_W     = 32;

  // Command queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Register port.
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_PIXEL_COUNT = '0;

  // Result status codes.
  localparam logic [1:0] STAT_PIXEL   = 2'd0;
  localparam logic [1:0] STAT_TRUNC   = 2'd1;
  localparam logic [1:0] STAT_OVERRUN = 2'd2;

  // Stream tags and arithmetic biases.
  localparam logic [7:0] TAG_RGB      = 8'hfe;
  localparam logic [7:0] TAG_RGBA     = 8'hff;
  localparam logic [7:0] DIFF_BIAS    = 8'd254;
  localparam logic [7:0] LUMA_RB_BIAS = 8'd216;
  localparam logic [7:0] LUMA_G_BIAS  = 8'd224;
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [1:0] status;
    logic       image_done;
    logic       burst_last;
  } out_item_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } pixel_t;

  // Meaning of a byte when it is read as a tag.
  typedef enum logic [2:0] {
    OP_RGB,
    OP_RGBA,
    OP_INDEX,
    OP_DIFF,
    OP_LUMA,
    OP_RUN
  } op_class_t;

  typedef struct packed {
    op_class_t  op;
    logic [7:0] data;
    logic       eos;
  } cmd_t;

  typedef enum logic [3:0] {
    PH_TAG,
    PH_RGB_R,
    PH_RGB_G,
    PH_RGB_B,
    PH_RGBA_R,
    PH_RGBA_G,
    PH_RGBA_B,
    PH_RGBA_A,
    PH_LUMA
  } phase_t;

  typedef enum logic [1:0] {
    BS_CMD,
    BS_IDX,
    BS_RUN,
    BS_TRUNC
  } back_state_t;

  // Pixel count register value clipped to the supported maximum.
  function automatic logic [CNT_W-1:0] count_limit(input logic [PCOUNT_W-1:0] pc);
    logic [CMP_W-1:0] c;
    logic [CMP_W-1:0] top;
    c   = CMP_W'(pc);
    top = CMP_W'(1) << COUNT_BITS;
    return (c > top) ? CNT_W'(top) : CNT_W'(c);
  endfunction

  // Table slot: (3r + 5g + 7b + 11a) mod 64, worked in six bits.
  function automatic logic [TIDX_W-1:0] pixel_hash(input pixel_t p);
    return TIDX_W'(p.r) * TIDX_W'(3) + TIDX_W'(p.g) * TIDX_W'(5) +
           TIDX_W'(p.b) * TIDX_W'(7) + TIDX_W'(p.a) * TIDX_W'(11);
  endfunction

  function automatic op_class_t classify(input logic [7:0] b);
    op_class_t op;
    if (b == TAG_RGB) begin
      op = OP_RGB;
    end else if (b == TAG_RGBA) begin
      op = OP_RGBA;
    end else begin
      case (b[7:6])
        2'b00:   op = OP_INDEX;
        2'b01:   op = OP_DIFF;
        2'b10:   op = OP_LUMA;
        default: op = OP_RUN;
      endcase
    end
    return op;
  endfunction

endpackage

[hdl/qoi_ram.sv]
// ============================================================================
// qoi_ram
// Simple dual-port RAM with one write port and a registered read port.
// ============================================================================
module qoi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hdl/qoi_front.sv]
// ============================================================================
// qoi_front
// Accepts stream words, tags each byte with its op class and queues it.
// ============================================================================
module qoi_front
  import qoi_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  logic     pop,
  output logic     q_valid,
  output cmd_t     q_cmd
);

  cmd_t              qmem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   cnt_r;
  logic              push;
  logic              do_pop;
  cmd_t              new_cmd;

  assign in_stall = (cnt_r == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign do_pop   = pop && q_valid;
  assign q_cmd    = qmem_r[rd_ptr_r];

  always_comb begin
    new_cmd.op   = classify(in_data.stream_byte);
    new_cmd.data = in_data.stream_byte;
    new_cmd.eos  = in_data.end_of_stream;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      qmem_r[wr_ptr_r] <= new_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      case ({push, do_pop})
        2'b10:   cnt_r <= cnt_r + (QPTR_W + 1)'(1);
        2'b01:   cnt_r <= cnt_r - (QPTR_W + 1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

[hdl/qoi_back.sv]
// ============================================================================
// qoi_back
// Executes queued bytes against the decoder state and drives the result register.
// ============================================================================
module qoi_back
  import qoi_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CNT_W-1:0] lim,
  input  logic             q_valid,
  input  cmd_t             q_cmd,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data
);

  back_state_t              state_r,    state_nxt;
  phase_t                   phase_r,    phase_nxt;
  pixel_t                   px_r,       px_nxt;
  logic [5:0]               dg_r,       dg_nxt;
  logic [CNT_W-1:0]         written_r,  written_nxt;
  logic                     closed_r,   closed_nxt;
  logic [TABLE_DEPTH-1:0]   valid_r,    valid_nxt;
  logic [TIDX_W-1:0]        idx_addr_r, idx_addr_nxt;
  logic                     eos_r,      eos_nxt;
  logic [5:0]               run_left_r, run_left_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_data_r,  out_data_nxt;

  logic                     out_free;
  logic                     active;
  logic [CNT_W-1:0]         written_inc;
  logic                     done_inc;
  logic [CNT_W:0]           run_end;
  pixel_t                   px_new;
  pixel_t                   ram_rd_px;
  logic                     do_push;
  logic                     do_pixel;
  logic                     final_px;
  logic                     eos_cur;
  logic                     start;
  logic                     ram_we;
  logic [TIDX_W-1:0]        ram_waddr;
  logic [TIDX_W-1:0]        ram_raddr;
  logic [PIXEL_W-1:0]       ram_rdata;
  logic [TIDX_W-1:0]        hash_new;

  qoi_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (TABLE_DEPTH)
  ) u_qoi_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (px_new),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_rd_px   = ram_rdata;
  assign out_free    = !out_valid_r || !out_stall;
  assign active      = !closed_r && (written_r < lim);
  assign written_inc = written_r + CNT_W'(1);
  assign done_inc    = (written_inc >= lim);
  assign run_end     = {1'b0, written_r} + (CNT_W + 1)'(q_cmd.data[5:0]) + (CNT_W + 1)'(1);
  assign hash_new    = pixel_hash(px_new);
  assign ram_waddr   = hash_new;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    dg_nxt        = dg_r;
    written_nxt   = written_r;
    closed_nxt    = closed_r;
    valid_nxt     = valid_r;
    idx_addr_nxt  = idx_addr_r;
    eos_nxt       = eos_r;
    run_left_nxt  = run_left_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    px_new        = px_r;
    pop           = 1'b0;
    do_push       = 1'b0;
    do_pixel      = 1'b0;
    final_px      = 1'b0;
    eos_cur       = eos_r;
    start         = 1'b0;
    ram_we        = 1'b0;
    ram_raddr     = idx_addr_r;

    case (state_r)
      BS_CMD: begin
        if (q_valid && out_free) begin
          pop     = 1'b1;
          eos_nxt = q_cmd.eos;
          eos_cur = q_cmd.eos;
          if (active) begin
            case (phase_r)
              PH_TAG: begin
                case (q_cmd.op)
                  OP_RGB:  phase_nxt = PH_RGB_R;
                  OP_RGBA: phase_nxt = PH_RGBA_R;
                  OP_INDEX: begin
                    idx_addr_nxt = q_cmd.data[TIDX_W-1:0];
                    ram_raddr    = q_cmd.data[TIDX_W-1:0];
                    state_nxt    = BS_IDX;
                  end
                  OP_DIFF: begin
                    px_new.r = px_r.r + {6'b0, q_cmd.data[5:4]} + DIFF_BIAS;
                    px_new.g = px_r.g + {6'b0, q_cmd.data[3:2]} + DIFF_BIAS;
                    px_new.b = px_r.b + {6'b0, q_cmd.data[1:0]} + DIFF_BIAS;
                    do_push  = 1'b1;
                  end
                  OP_LUMA: begin
                    dg_nxt    = q_cmd.data[5:0];
                    phase_nxt = PH_LUMA;
                  end
                  default: begin
                    if (run_end > {1'b0, lim}) begin
                      // Run would overshoot the image: report it and close.
                      out_valid_nxt         = 1'b1;
                      out_data_nxt          = '0;
                      out_data_nxt.status   = STAT_OVERRUN;
                      out_data_nxt.burst_last = 1'b1;
                      closed_nxt            = 1'b1;
                      start                 = q_cmd.eos;
                    end else begin
                      run_left_nxt = q_cmd.data[5:0];
                      state_nxt    = BS_RUN;
                    end
                  end
                endcase
              end
              PH_RGB_R: begin
                px_new.r  = q_cmd.data;
                phase_nxt = PH_RGB_G;
              end
              PH_RGB_G: begin
                px_new.g  = q_cmd.data;
                phase_nxt = PH_RGB_B;
              end
              PH_RGB_B: begin
                px_new.b  = q_cmd.data;
                phase_nxt = PH_TAG;
                do_push   = 1'b1;
              end
              PH_RGBA_R: begin
                px_new.r  = q_cmd.data;
                phase_nxt = PH_RGBA_G;
              end
              PH_RGBA_G: begin
                px_new.g  = q_cmd.data;
                phase_nxt = PH_RGBA_B;
              end
              PH_RGBA_B: begin
                px_new.b  = q_cmd.data;
                phase_nxt = PH_RGBA_A;
              end
              PH_RGBA_A: begin
                px_new.a  = q_cmd.data;
                phase_nxt = PH_TAG;
                do_push   = 1'b1;
              end
              default: begin
                px_new.r  = px_r.r + {2'b0, dg_r} + LUMA_RB_BIAS + {4'b0, q_cmd.data[7:4]};
                px_new.g  = px_r.g + {2'b0, dg_r} + LUMA_G_BIAS;
                px_new.b  = px_r.b + {2'b0, dg_r} + LUMA_RB_BIAS + {4'b0, q_cmd.data[3:0]};
                phase_nxt = PH_TAG;
                do_push   = 1'b1;
              end
            endcase
          end
          // A closing byte that makes no pixel of its own.
          if (q_cmd.eos && !do_push && (state_nxt == BS_CMD) && !start) begin
            if (active) begin
              out_valid_nxt           = 1'b1;
              out_data_nxt            = '0;
              out_data_nxt.status     = STAT_TRUNC;
              out_data_nxt.burst_last = 1'b1;
            end
            start = 1'b1;
          end
        end
      end
      BS_IDX: begin
        if (out_free) begin
          px_new    = valid_r[idx_addr_r] ? ram_rd_px : '0;
          do_push   = 1'b1;
          state_nxt = BS_CMD;
        end
      end
      BS_RUN: begin
        if (out_free) begin
          do_pixel     = 1'b1;
          final_px     = (run_left_r == '0);
          run_left_nxt = run_left_r - 6'd1;
          if (run_left_r == '0) begin
            state_nxt = BS_CMD;
          end
        end
      end
      BS_TRUNC: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt            = '0;
          out_data_nxt.status     = STAT_TRUNC;
          out_data_nxt.burst_last = 1'b1;
          start                   = 1'b1;
          state_nxt               = BS_CMD;
        end
      end
      default: state_nxt = BS_CMD;
    endcase

    if (do_push) begin
      ram_we                         = 1'b1;
      valid_nxt[pixel_hash(px_new)]  = 1'b1;
      do_pixel                       = 1'b1;
      final_px                       = 1'b1;
    end

    if (do_pixel) begin
      written_nxt = written_inc;
      if (done_inc) begin
        closed_nxt = 1'b1;
      end
      out_valid_nxt           = 1'b1;
      out_data_nxt.red        = px_new.r;
      out_data_nxt.green      = px_new.g;
      out_data_nxt.blue       = px_new.b;
      out_data_nxt.alpha      = px_new.a;
      out_data_nxt.status     = STAT_PIXEL;
      out_data_nxt.image_done = done_inc;
      out_data_nxt.burst_last = final_px && !(eos_cur && !done_inc);
      if (final_px && eos_cur) begin
        if (!done_inc) begin
          state_nxt = BS_TRUNC;
        end else begin
          start = 1'b1;
        end
      end
    end

    px_nxt = px_new;

    // Image boundary: restore the per-image state.
    if (start) begin
      valid_nxt   = '0;
      px_nxt      = '{r: 8'd0, g: 8'd0, b: 8'd0, a: ALPHA_OPAQUE};
      phase_nxt   = PH_TAG;
      dg_nxt      = '0;
      written_nxt = '0;
      closed_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_CMD;
      phase_r     <= PH_TAG;
      px_r        <= '{r: 8'd0, g: 8'd0, b: 8'd0, a: ALPHA_OPAQUE};
      dg_r        <= '0;
      written_r   <= '0;
      closed_r    <= 1'b0;
      valid_r     <= '0;
      eos_r       <= 1'b0;
      run_left_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      px_r        <= px_nxt;
      dg_r        <= dg_nxt;
      written_r   <= written_nxt;
      closed_r    <= closed_nxt;
      valid_r     <= valid_nxt;
      eos_r       <= eos_nxt;
      run_left_r  <= run_left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_addr_r <= idx_addr_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A run only ever emits pixels into an open image.
  a_run_open: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BS_RUN) |-> !closed_r)
    else $error("run in progress on a closed image");

  // Error results always end their byte's burst.
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status != STAT_PIXEL)) |-> out_data_r.burst_last)
    else $error("error result not marked as last of burst");

  // The pixel that completes the image is the last result of its byte.
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.image_done) |-> out_data_r.burst_last)
    else $error("image_done pixel followed by more results");

  // A table lookup is always started from the command state.
  a_idx_entry: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == BS_IDX) |-> ($past(state_r) == BS_CMD))
    else $error("index lookup entered from an unexpected state");

endmodule

[hdl/qoi_pixel_stream_decoder_top.sv]
// ============================================================================
// qoi_pixel_stream_decoder_top
// Headerless QOI stream decoder: one encoded byte in, RGBA pixels out.
// ============================================================================
// Usage: the input channel carries one stream byte per word, with
// end_of_stream set on the final byte of an image. The result channel
// carries one pixel or one status word per word; burst_last marks the last
// word caused by a given input byte, and image_done the pixel that reaches
// pixel_count. The register port holds pixel_count at byte address 0. The
// user must write it only while the decoder is idle; nothing enforces it.
// Execution: a byte lands in a two-entry command queue; the execute stage
// takes it from the queue head and loads the output register. An index
// byte also passes through the lookup state, as the table is a RAM with a
// registered read, and a run byte through the run state, which emits the
// repeated pixels in turn; no new byte is popped meanwhile. A closing byte
// that leaves a pixel in a short image passes through the truncation state
// for its truncation word; a closing byte with no pixel of its own carries
// that word from the command state.
// Reset clears the pixel state, the counters and the table's valid bits at
// once, so the table needs no clearing pass; the same happens at every
// end_of_stream. When the receiver stalls, the output word holds, execution
// pauses, and in_stall rises once the command queue is full.
// ============================================================================
module qoi_pixel_stream_decoder_top
  import qoi_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // Stream input.
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_data,
  // Decoded output.
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_data,
  // Register port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [PCOUNT_W-1:0] pixel_count_r;
  logic [CNT_W-1:0]    lim_r;
  logic                reg_sel;
  logic                q_valid;
  cmd_t                q_cmd;
  logic                pop;

  // Register decode: the word address picks the register.
  assign reg_sel = (paddr[PADDR_W-1:2] == REG_PIXEL_COUNT);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? PDATA_W'(pixel_count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_count_r <= PCOUNT_W'(1);
      lim_r         <= count_limit(PCOUNT_W'(1));
    end else begin
      if (psel && penable && pwrite && pready && reg_sel) begin
        pixel_count_r <= pwdata[PCOUNT_W-1:0];
      end
      // The clipped count is registered; it settles while the block is idle.
      lim_r <= count_limit(pixel_count_r);
    end
  end

  // Front: accepts bytes, classifies the tag and queues the command.
  qoi_front u_qoi_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  // Back: runs the decoder state machine and owns the index table.
  qoi_back u_qoi_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .lim       (lim_r),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[verif/qoi_pixel_stream_decoder_top_tb.sv]
// ============================================================================
// qoi_pixel_stream_decoder_top_tb
// Self-checking bench for the QOI pixel stream decoder.
// ============================================================================
// A short directed table covers the reset count, zero and maximum counts,
// every tag, runs at both ends of their length range, run overflow,
// truncation and a count lowered mid-image. A random section follows with
// mostly well-formed images of random content. Every accepted byte is run
// through a behavioral decoder in the bench. Each result word is compared
// with the oldest word that decoder predicted. Both channels idle and stall
// in random bursts, except near the end of the run.
// ============================================================================
module qoi_pixel_stream_decoder_top_tb;
  import qoi_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 16;
  localparam int RANDOM_BYTES   = 180;
  localparam int QUIET_AFTER    = 150;
  localparam logic [PADDR_W-1:0] ADDR_COUNT = PADDR_W'({REG_PIXEL_COUNT, 2'b00});

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  in_item_t           in_data;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_item_t          out_data;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  qoi_pixel_stream_decoder_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Behavioral decoder. It holds its own copy of the pixel state, the index
  // table and the pixel_count register, and turns each accepted byte into
  // the words the decoder must produce for it.
  // --------------------------------------------------------------------------
  pixel_t      slot_tab [0:63];
  pixel_t      cur_px;
  phase_t      phase;
  logic [7:0]  luma_dg;
  logic [31:0] written;
  logic        closed;
  logic [24:0] count_reg;

  // Words caused by the byte being decoded, before burst_last is marked.
  out_item_t   burst_buf [0:63];
  int          burst_n;

  // Words still owed by the decoder, oldest first.
  out_item_t   pending_words [$];

  // Per-byte side information from the driver: a typed-in expectation or not.
  bit          hint_typed [$];
  out_item_t   hint_want [$];

  int          mismatches = 0;
  int          idle_cycles = 0;
  int          random_sent = 0;
  bit          quiet = 1'b0;
  bit          busy;

  function automatic logic [5:0] slot_of(input pixel_t p);
    int s;
    s = 3 * p.r + 5 * p.g + 7 * p.b + 11 * p.a;
    return s[5:0];
  endfunction

  task automatic start_image();
    for (int i = 0; i < 64; i++) slot_tab[i] = '0;
    cur_px  = {8'd0, 8'd0, 8'd0, ALPHA_OPAQUE};
    phase   = PH_TAG;
    luma_dg = '0;
    written = '0;
    closed  = 1'b0;
  endtask

  task automatic add_word(input pixel_t p, input logic [1:0] st, input logic done);
    burst_buf[burst_n] = {p, st, done, 1'b0};
    burst_n++;
  endtask

  task automatic emit_current(input logic [31:0] lim);
    written++;
    if (written >= lim) closed = 1'b1;
    add_word(cur_px, STAT_PIXEL, written >= lim);
  endtask

  task automatic store_and_emit(input logic [31:0] lim);
    slot_tab[slot_of(cur_px)] = cur_px;
    emit_current(lim);
  endtask

  task automatic decode_byte(input in_item_t word, input bit typed, input out_item_t want);
    logic [7:0]  b;
    logic [31:0] lim;
    logic [31:0] run_len;
    out_item_t   w;
    b       = word.stream_byte;
    burst_n = 0;
    // Counts above 2**COUNT_BITS saturate.
    lim = (count_reg > 25'h1000000) ? 32'h1000000 : 32'(count_reg);
    if (!closed && written < lim) begin
      case (phase)
        PH_TAG: begin
          if (b == TAG_RGB) begin
            phase = PH_RGB_R;
          end else if (b == TAG_RGBA) begin
            phase = PH_RGBA_R;
          end else begin
            case (b[7:6])
              2'b00: begin
                cur_px = slot_tab[b[5:0]];
                store_and_emit(lim);
              end
              2'b01: begin
                cur_px.r = cur_px.r + 8'(b[5:4]) + DIFF_BIAS;
                cur_px.g = cur_px.g + 8'(b[3:2]) + DIFF_BIAS;
                cur_px.b = cur_px.b + 8'(b[1:0]) + DIFF_BIAS;
                store_and_emit(lim);
              end
              2'b10: begin
                luma_dg = 8'(b[5:0]);
                phase   = PH_LUMA;
              end
              default: begin
                // A run repeats the current pixel and leaves the table alone.
                run_len = 32'(b[5:0]) + 32'd1;
                if (written + run_len > lim) begin
                  add_word('0, STAT_OVERRUN, 1'b0);
                  closed = 1'b1;
                end else begin
                  repeat (run_len) emit_current(lim);
                end
              end
            endcase
          end
        end
        PH_RGB_R: begin
          cur_px.r = b;
          phase    = PH_RGB_G;
        end
        PH_RGB_G: begin
          cur_px.g = b;
          phase    = PH_RGB_B;
        end
        PH_RGB_B: begin
          cur_px.b = b;
          phase    = PH_TAG;
          store_and_emit(lim);
        end
        PH_RGBA_R: begin
          cur_px.r = b;
          phase    = PH_RGBA_G;
        end
        PH_RGBA_G: begin
          cur_px.g = b;
          phase    = PH_RGBA_B;
        end
        PH_RGBA_B: begin
          cur_px.b = b;
          phase    = PH_RGBA_A;
        end
        PH_RGBA_A: begin
          cur_px.a = b;
          phase    = PH_TAG;
          store_and_emit(lim);
        end
        default: begin
          cur_px.r = cur_px.r + luma_dg + LUMA_RB_BIAS + 8'(b[7:4]);
          cur_px.g = cur_px.g + luma_dg + LUMA_G_BIAS;
          cur_px.b = cur_px.b + luma_dg + LUMA_RB_BIAS + 8'(b[3:0]);
          phase    = PH_TAG;
          store_and_emit(lim);
        end
      endcase
    end
    if (word.end_of_stream) begin
      // A short image, including one cut off inside a multi-byte op, reports
      // truncation after the pixels of its closing byte.
      if (!closed && written < lim) add_word('0, STAT_TRUNC, 1'b0);
      start_image();
    end
    if (typed) begin
      pending_words.push_back(want);
    end else begin
      for (int i = 0; i < burst_n; i++) begin
        w            = burst_buf[i];
        w.burst_last = (i == burst_n - 1);
        pending_words.push_back(w);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Checking.
  // --------------------------------------------------------------------------
  task automatic log_mismatch(input string msg);
    if (mismatches < 10) $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_word(input out_item_t got);
    out_item_t want;
    if (pending_words.size() == 0) begin
      log_mismatch($sformatf("unexpected word r=%h g=%h b=%h a=%h st=%0d done=%b last=%b",
                             got.red, got.green, got.blue, got.alpha, got.status,
                             got.image_done, got.burst_last));
    end else begin
      want = pending_words.pop_front();
      if (got !== want) begin
        log_mismatch($sformatf({"want r=%h g=%h b=%h a=%h st=%0d done=%b last=%b, ",
                                "got r=%h g=%h b=%h a=%h st=%0d done=%b last=%b"},
                               want.red, want.green, want.blue, want.alpha, want.status,
                               want.image_done, want.burst_last,
                               got.red, got.green, got.blue, got.alpha, got.status,
                               got.image_done, got.burst_last));
      end
    end
  endtask

  // Both channels and the register port are sampled at the rising edge.
  // A result word is checked before the byte accepted at the same edge is
  // decoded; the decoder's latency keeps the two unrelated. The watchdog
  // counts edges at which nothing moves on any port.
  always @(posedge clk) begin
    if (rst_n) begin
      busy = 1'b0;
      if (out_valid && !out_stall) begin
        busy = 1'b1;
        check_word(out_data);
      end
      if (in_valid && !in_stall) begin
        busy = 1'b1;
        decode_byte(in_data, hint_typed.pop_front(), hint_want.pop_front());
      end
      if (psel && penable && pready) busy = 1'b1;
      idle_cycles = busy ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL qoi_pixel_stream_decoder_top");
        $finish;
      end
    end
  end

  // Receiver stalls come in bursts of random length separated by free
  // stretches; near the end of the run the receiver never stalls.
  int stall_hold = 0;
  always @(negedge clk) begin
    if (quiet) begin
      out_stall = 1'b0;
    end else if (stall_hold > 0) begin
      stall_hold--;
    end else if (out_stall) begin
      out_stall  = 1'b0;
      stall_hold = $urandom_range(1, 24);
    end else if ($urandom_range(0, 2) == 0) begin
      out_stall  = 1'b1;
      stall_hold = $urandom_range(0, 15);
    end
  end

  // --------------------------------------------------------------------------
  // Drivers. Inputs change at the falling edge only.
  // --------------------------------------------------------------------------

  // Offers one word and returns at the rising edge that accepts it. The
  // sender sometimes idles for a random gap first.
  task automatic send_byte(input logic [7:0] b, input bit eos, input bit typed,
                           input out_item_t want);
    int gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap      = $urandom_range(1, 16);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = {b, eos};
    hint_typed.push_back(typed);
    hint_want.push_back(want);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Lets the decoder go idle: every owed word has arrived, and bytes that
  // cause no word have had time to leave the command queue.
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes pixel_count, then reads it back.
  task automatic write_count(input logic [31:0] value);
    logic [PDATA_W-1:0] rd;
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = ADDR_COUNT;
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    count_reg = value[24:0];
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    if (rd[24:0] !== value[24:0])
      log_mismatch($sformatf("pixel_count read back %h, written %h", rd[24:0], value[24:0]));
  endtask

  // --------------------------------------------------------------------------
  // Directed table. A row may first write pixel_count; its byte is then sent.
  // Rows with a typed-in word must cause exactly that one word.
  // --------------------------------------------------------------------------
  typedef struct packed {
    logic        wr;
    logic [31:0] pc;
    in_item_t    item;
    logic        typed;
    out_item_t   want;
  } dir_row_t;

  dir_row_t dir_rows [$];

  task automatic add_row(input logic wr, input logic [31:0] pc, input logic [7:0] b,
                         input logic eos, input logic typed, input out_item_t want);
    dir_rows.push_back({wr, pc, {b, eos}, typed, want});
  endtask

  task automatic load_directed();
    // Reset count of one: an index op on the cleared table is transparent
    // black and finishes the image; the closing byte after it is ignored.
    add_row(0, 0, 8'h00, 0, 1, {8'h00, 8'h00, 8'h00, 8'h00, STAT_PIXEL, 1'b1, 1'b1});
    add_row(0, 0, 8'haa, 1, 0, '0);
    // Diff of -1 on every channel wraps the start pixel to white.
    add_row(1, 3, 8'h55, 0, 1, {8'hff, 8'hff, 8'hff, 8'hff, STAT_PIXEL, 1'b0, 1'b1});
    add_row(0, 0, TAG_RGB, 0, 0, '0);
    add_row(0, 0, 8'h00, 0, 0, '0);
    add_row(0, 0, 8'hff, 0, 0, '0);
    add_row(0, 0, 8'h80, 0, 0, '0);
    // Shortest run closes the image; the byte after it is ignored.
    add_row(0, 0, 8'hc0, 0, 0, '0);
    add_row(0, 0, 8'h12, 1, 0, '0);
    // A zero count is already complete: nothing, not even truncation.
    add_row(1, 0, 8'h40, 1, 0, '0);
    // Largest register value saturates; RGBA with zero alpha.
    add_row(1, 32'h01ff_ffff, TAG_RGBA, 0, 0, '0);
    add_row(0, 0, 8'h12, 0, 0, '0);
    add_row(0, 0, 8'h34, 0, 0, '0);
    add_row(0, 0, 8'h56, 0, 0, '0);
    add_row(0, 0, 8'h00, 0, 1, {8'h12, 8'h34, 8'h56, 8'h00, STAT_PIXEL, 1'b0, 1'b1});
    // Luma at both ends of its green delta, the second closing a short image.
    add_row(0, 0, 8'h80, 0, 0, '0);
    add_row(0, 0, 8'hff, 0, 0, '0);
    add_row(0, 0, 8'hbf, 0, 0, '0);
    add_row(0, 0, 8'h00, 1, 0, '0);
    // Longest run, then end of stream in the middle of an RGB op.
    add_row(0, 0, 8'hfd, 0, 0, '0);
    add_row(0, 0, TAG_RGB, 1, 1, {8'h00, 8'h00, 8'h00, 8'h00, STAT_TRUNC, 1'b0, 1'b1});
    // Run that would pass the count closes the image with an overrun word.
    add_row(1, 5, 8'hc1, 0, 0, '0);
    add_row(0, 0, 8'hc3, 0, 1, {8'h00, 8'h00, 8'h00, 8'h00, STAT_OVERRUN, 1'b0, 1'b1});
    add_row(0, 0, 8'h3f, 1, 0, '0);
    // Count lowered to the pixels already out: the image counts as complete.
    add_row(1, 4, 8'h7f, 0, 0, '0);
    add_row(1, 1, 8'h55, 1, 0, '0);
  endtask

  // --------------------------------------------------------------------------
  // Random images: mostly well-formed op sequences with random content, some
  // cut short, some ending inside an op, some with trailing noise.
  // --------------------------------------------------------------------------
  task automatic random_image();
    logic [7:0]  img_bytes [$];
    logic [31:0] pc;
    int          sel;
    int          cnt;
    int          target;
    int          made;
    int          room;
    int          len;
    img_bytes.delete();
    quiet = (random_sent >= QUIET_AFTER);
    sel   = $urandom_range(0, 11);
    if (sel == 0)      pc = 0;
    else if (sel == 1) pc = 32'h01ff_ffff;
    else if (sel == 2) pc = 32'h0100_0000;
    else if (sel == 3) pc = 1;
    else               pc = $urandom_range(2, 30);
    if (sel < 4 || $urandom_range(0, 1) == 0) begin
      settle();
      write_count(pc);
    end
    cnt = count_reg;
    if (cnt > 30)                      target = $urandom_range(1, 70);
    else if (cnt == 0)                 target = $urandom_range(1, 3);
    else if ($urandom_range(0, 3) == 0) target = $urandom_range(0, cnt - 1);
    else                               target = cnt;
    made = 0;
    while (made < target) begin
      case ($urandom_range(0, 11))
        0: begin
          img_bytes.push_back(TAG_RGB);
          repeat (3) img_bytes.push_back(8'($urandom));
          made++;
        end
        1: begin
          img_bytes.push_back(TAG_RGBA);
          repeat (4) img_bytes.push_back(8'($urandom));
          made++;
        end
        2, 3: begin
          img_bytes.push_back({2'b00, 6'($urandom)});
          made++;
        end
        4, 5: begin
          img_bytes.push_back({2'b01, 6'($urandom)});
          made++;
        end
        6, 7: begin
          img_bytes.push_back({2'b10, 6'($urandom)});
          img_bytes.push_back(8'($urandom));
          made++;
        end
        8, 9: begin
          room = target - made;
          if (room > 62) room = 62;
          // Now and then a run is allowed to overshoot the count.
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 62) : $urandom_range(1, room);
          img_bytes.push_back({2'b11, 6'(len - 1)});
          made += len;
        end
        default: img_bytes.push_back(8'($urandom));
      endcase
    end
    if ($urandom_range(0, 5) == 0) begin
      if ($urandom_range(0, 1) == 0) begin
        img_bytes.push_back({2'b10, 6'($urandom)});
      end else begin
        img_bytes.push_back($urandom_range(0, 1) ? TAG_RGB : TAG_RGBA);
        repeat ($urandom_range(0, 2)) img_bytes.push_back(8'($urandom));
      end
    end else if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) img_bytes.push_back(8'($urandom));
    end
    if (img_bytes.size() == 0) img_bytes.push_back(8'($urandom));
    foreach (img_bytes[i])
      send_byte(img_bytes[i], i == img_bytes.size() - 1, 1'b0, '0);
    random_sent += img_bytes.size();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    count_reg = 25'd1;
    start_image();
    load_directed();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].wr) begin
        settle();
        write_count(dir_rows[i].pc);
      end
      send_byte(dir_rows[i].item.stream_byte, dir_rows[i].item.end_of_stream,
                dir_rows[i].typed, dir_rows[i].want);
    end

    while (random_sent < RANDOM_BYTES) random_image();

    settle();
    if (mismatches == 0) begin
      $display("PASS qoi_pixel_stream_decoder_top");
    end else begin
      $display("FAIL qoi_pixel_stream_decoder_top");
    end
    $finish;
  end

endmodule

[qoi_pixel_stream_decoder_top.f]
hdl/qoi_pkg.sv
hdl/qoi_ram.sv
hdl/qoi_front.sv
hdl/qoi_back.sv
hdl/qoi_pixel_stream_decoder_top.sv
verif/qoi_pixel_stream_decoder_top_tb.sv
